### src/assert_macros.svh
// assertion helpers for the accumulator checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

`define ASSERT_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

### src/vga_pkg.sv
`default_nettype none
package vga_pkg;
   localparam int TableDepth = 1024;
   localparam int AddrW = $clog2(TableDepth);
   localparam int CountW = AddrW + 1;
   localparam int CoordW = 24;
   localparam int CellW = 20;
   localparam int KeyW = 3 * CellW;
   localparam int CsrW = 48;
   localparam int CsrIdxW = 3;

   localparam logic [CsrIdxW-1:0] CSR_ROT_X = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_ROT_Y = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_ROT_Z = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_TRANS_X = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_TRANS_Y = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_TRANS_Z = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_SCALE = 3'd6;

   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_OCCUPIED = 3'd1;
   localparam logic [2:0] ST_FULL = 3'd2;
   localparam logic [2:0] ST_READ_OK = 3'd3;
   localparam logic [2:0] ST_BAD_INDEX = 3'd4;

   typedef struct packed {
      logic [2:0] status;
      logic signed [CoordW-1:0] out_x;
      logic signed [CoordW-1:0] out_y;
      logic signed [CoordW-1:0] out_z;
      logic signed [CellW-1:0] cell_x;
      logic signed [CellW-1:0] cell_y;
      logic signed [CellW-1:0] cell_z;
      logic [10:0] entry_count;
      logic clipped;
   } rsp_type;

   typedef struct packed {
      logic req_type;
      logic signed [CoordW-1:0] pos_x;
      logic signed [CoordW-1:0] pos_y;
      logic signed [CoordW-1:0] pos_z;
      logic [9:0] read_index;
   } req_type_type;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_ROW, S_CELL, S_SEARCH_ADDR, S_SEARCH_CMP, S_APPEND,
      S_READ_WAIT, S_READ_DATA, S_DONE
   } state_type;

   // xform unit control from sequencer
   typedef struct packed {
      logic start;
   } xf_ctl_type;

   typedef struct packed {
      logic done;
   } xf_sts_type;
endpackage
`default_nettype wire

### src/vga_if.sv
`default_nettype none
interface vga_req_if;
   logic valid;
   logic ready;
   vga_pkg::req_type_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

interface vga_rsp_if;
   logic valid;
   logic ready;
   vga_pkg::rsp_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

### src/voxel_grid_point_accumulator_core.sv
// channel  dir  beat
// req      in   req_type, pos_x/y/z, read_index
// rsp      out  status, out_x/y/z, cell_x/y/z, entry_count, clipped
// csr      in   write enable, index, data
// add: the products run through the shared multiplier (S_MUL), S_ROW settles, each stored key
// compared takes S_SEARCH_ADDR and S_SEARCH_CMP, then S_APPEND (no match) writes and S_DONE posts the rsp beat
// read: S_READ_WAIT, then S_READ_DATA registers the rsp beat after the req beat
// reset clears the count and control, stores need no clearing
// req is ready only when idle and the response register is empty
`default_nettype none
module voxel_grid_point_accumulator_core (
   input wire logic clock,
   input wire logic reset,
   vga_req_if.sink req,
   vga_rsp_if.source rsp,
   input wire logic csr_we,
   input wire logic [vga_pkg::CsrIdxW-1:0] csr_index,
   input wire logic [vga_pkg::CsrW-1:0] csr_data
);
   import vga_pkg::*;

   logic [47:0] rot_x_ff, rot_y_ff, rot_z_ff;
   logic [23:0] tr_x_ff, tr_y_ff, tr_z_ff;
   logic [15:0] scale_ff;
   state_type state_ff, state_in;
   req_type_type req_ff;
   logic [CountW-1:0] count_ff, count_in;
   logic [CountW-1:0] idx_ff, idx_in;
   logic rsp_vld_ff, rsp_vld_in;
   rsp_type rsp_ff, rsp_in;
   xf_ctl_type xf_ctl;
   xf_sts_type xf_sts;
   logic signed [23:0] pt_x, pt_y, pt_z;
   logic signed [19:0] cl_x, cl_y, cl_z;
   logic clip;
   logic [KeyW-1:0] key_rd, key;
   logic [3*CoordW-1:0] pt_rd;
   logic wr_en;
   logic [AddrW-1:0] rd_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_x_ff <= 48'd16384;
         rot_y_ff <= 48'd1073741824;
         rot_z_ff <= 48'd70368744177664;
         tr_x_ff <= '0;
         tr_y_ff <= '0;
         tr_z_ff <= '0;
         scale_ff <= 16'd5120;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROT_X: rot_x_ff <= csr_data;
            CSR_ROT_Y: rot_y_ff <= csr_data;
            CSR_ROT_Z: rot_z_ff <= csr_data;
            CSR_TRANS_X: tr_x_ff <= csr_data[23:0];
            CSR_TRANS_Y: tr_y_ff <= csr_data[23:0];
            CSR_TRANS_Z: tr_z_ff <= csr_data[23:0];
            CSR_SCALE: scale_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   vga_xform u_xform (
      .clock(clock), .reset(reset), .ctl(xf_ctl), .sts(xf_sts),
      .pos_x(req_ff.pos_x), .pos_y(req_ff.pos_y), .pos_z(req_ff.pos_z),
      .rot_x(rot_x_ff), .rot_y(rot_y_ff), .rot_z(rot_z_ff),
      .trans_x(tr_x_ff), .trans_y(tr_y_ff), .trans_z(tr_z_ff),
      .scale(scale_ff), .pt_x(pt_x), .pt_y(pt_y), .pt_z(pt_z),
      .cl_x(cl_x), .cl_y(cl_y), .cl_z(cl_z), .clip(clip)
   );

   assign key = {cl_z, cl_y, cl_x};

   vga_ram #(.Width(KeyW), .Depth(TableDepth)) u_key_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(count_ff[AddrW-1:0]), .wr_data(key),
      .rd_addr(rd_addr), .rd_data(key_rd)
   );

   vga_ram #(.Width(3*CoordW), .Depth(TableDepth)) u_pt_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(count_ff[AddrW-1:0]),
      .wr_data({pt_z, pt_y, pt_x}), .rd_addr(rd_addr), .rd_data(pt_rd)
   );

   assign req.ready = (state_ff == S_IDLE) && !rsp_vld_ff;
   assign rsp.valid = rsp_vld_ff;
   assign rsp.data = rsp_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      rsp_vld_in = rsp_vld_ff;
      rsp_in = rsp_ff;
      xf_ctl.start = 1'b0;
      wr_en = 1'b0;
      rd_addr = idx_ff[AddrW-1:0];
      if (rsp_vld_ff && rsp.ready) begin
         rsp_vld_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               if (req.data.req_type) begin
                  rd_addr = req.data.read_index;
                  state_in = S_READ_WAIT;
               end else begin
                  xf_ctl.start = 1'b1;
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            idx_in = '0;
            if (xf_sts.done) begin
               state_in = S_ROW;
            end
         end
         S_ROW: begin
            state_in = S_SEARCH_ADDR;
         end
         S_SEARCH_ADDR: begin
            if (idx_ff >= count_ff) begin
               state_in = S_APPEND;
            end else begin
               state_in = S_SEARCH_CMP;
            end
         end
         S_SEARCH_CMP: begin
            rsp_in.status = ST_OCCUPIED;
            if (key_rd == key) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + CountW'(1);
               state_in = S_SEARCH_ADDR;
            end
         end
         S_APPEND: begin
            if (count_ff >= CountW'(TableDepth)) begin
               rsp_in.status = ST_FULL;
            end else begin
               wr_en = 1'b1;
               count_in = count_ff + CountW'(1);
               rsp_in.status = ST_INSERTED;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_in.out_x = pt_x;
            rsp_in.out_y = pt_y;
            rsp_in.out_z = pt_z;
            rsp_in.cell_x = cl_x;
            rsp_in.cell_y = cl_y;
            rsp_in.cell_z = cl_z;
            rsp_in.clipped = clip;
            rsp_in.entry_count = 11'(count_ff);
            rsp_vld_in = 1'b1;
            state_in = S_IDLE;
         end
         S_READ_WAIT: begin
            state_in = S_READ_DATA;
         end
         S_READ_DATA: begin
            rsp_in.entry_count = 11'(count_ff);
            rsp_in.clipped = 1'b0;
            if (CountW'(req_ff.read_index) < count_ff) begin
               rsp_in.status = ST_READ_OK;
               rsp_in.out_x = pt_rd[23:0];
               rsp_in.out_y = pt_rd[47:24];
               rsp_in.out_z = pt_rd[71:48];
               rsp_in.cell_x = key_rd[19:0];
               rsp_in.cell_y = key_rd[39:20];
               rsp_in.cell_z = key_rd[59:40];
            end else begin
               rsp_in.status = ST_BAD_INDEX;
               rsp_in.out_x = '0;
               rsp_in.out_y = '0;
               rsp_in.out_z = '0;
               rsp_in.cell_x = '0;
               rsp_in.cell_y = '0;
               rsp_in.cell_z = '0;
            end
            rsp_vld_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_READ_WAIT) begin
         rd_addr = req_ff.read_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
      if (req.valid && req.ready) begin
         req_ff <= req.data;
      end
   end
endmodule
`default_nettype wire

### src/vga_ram.sv
`default_nettype none
module vga_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(Depth)-1:0] wr_addr,
   input wire logic [Width-1:0] wr_data,
   input wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### src/vga_xform.sv
`default_nettype none
// shared multiplier: 9 rotation products, then 3 scale products
module vga_xform (
   input wire logic clock,
   input wire logic reset,
   input wire vga_pkg::xf_ctl_type ctl,
   output vga_pkg::xf_sts_type sts,
   input wire logic signed [23:0] pos_x,
   input wire logic signed [23:0] pos_y,
   input wire logic signed [23:0] pos_z,
   input wire logic [47:0] rot_x,
   input wire logic [47:0] rot_y,
   input wire logic [47:0] rot_z,
   input wire logic [23:0] trans_x,
   input wire logic [23:0] trans_y,
   input wire logic [23:0] trans_z,
   input wire logic [15:0] scale,
   output logic signed [23:0] pt_x,
   output logic signed [23:0] pt_y,
   output logic signed [23:0] pt_z,
   output logic signed [19:0] cl_x,
   output logic signed [19:0] cl_y,
   output logic signed [19:0] cl_z,
   output logic clip
);
   import vga_pkg::*;

   // step 0..8 rotation products, 9..11 scale products, 12 last register
   logic [3:0] step_ff, step_in;
   logic busy_ff, busy_in;
   logic signed [41:0] acc_ff, acc_in;
   logic signed [40:0] prod_ff;
   logic prod_vld_ff;
   logic [3:0] prod_step_ff;
   logic signed [23:0] pt_ff [3];
   logic signed [19:0] cl_ff [3];
   logic clip_ff, clip_in;

   logic signed [23:0] mul_a;
   logic signed [16:0] mul_b;
   logic [1:0] row, col;
   logic [47:0] row_bits;
   logic signed [42:0] shifted;
   logic signed [42:0] sum_t;
   logic [23:0] tr_sel;
   logic signed [19:0] q_sat;
   logic signed [40:0] mag;
   logic signed [21:0] q;
   logic q_clip;
   logic [1:0] crow;

   // rotation row of a product step
   function automatic logic [1:0] row_of(logic [3:0] s);
      logic [1:0] v;
      if (s < 4'd3) begin
         v = 2'd0;
      end else if (s < 4'd6) begin
         v = 2'd1;
      end else begin
         v = 2'd2;
      end
      return v;
   endfunction

   // coefficient column of a product step
   function automatic logic [1:0] col_of(logic [3:0] s);
      logic [1:0] v;
      unique case (s)
         4'd0, 4'd3, 4'd6: v = 2'd0;
         4'd1, 4'd4, 4'd7: v = 2'd1;
         default: v = 2'd2;
      endcase
      return v;
   endfunction

   always_comb begin
      row = row_of(step_ff);
      col = col_of(step_ff);
      unique case (row)
         2'd0: row_bits = rot_x;
         2'd1: row_bits = rot_y;
         default: row_bits = rot_z;
      endcase
      unique case (col)
         2'd0: mul_a = pos_x;
         2'd1: mul_a = pos_y;
         default: mul_a = pos_z;
      endcase
      mul_b = {row_bits[16*col+15], row_bits[16*col +: 16]};
      if (step_ff >= 4'd9 && step_ff < 4'd12) begin
         crow = 2'(step_ff - 4'd9);
         mul_a = pt_ff[crow];
         mul_b = {1'b0, scale};
      end else begin
         crow = 2'd0;
      end
   end

   // row finish: floor shift, translate; cell: magnitude shift toward zero, saturate
   always_comb begin
      logic [1:0] r;
      r = row_of(prod_step_ff);
      unique case (r)
         2'd0: tr_sel = trans_x;
         2'd1: tr_sel = trans_y;
         default: tr_sel = trans_z;
      endcase
      shifted = 43'(acc_in >>> 14);
      sum_t = shifted + 43'(signed'(tr_sel));
      mag = prod_ff[40] ? -prod_ff : prod_ff;
      q = 22'(mag >>> 20);
      q_clip = 1'b0;
      if (q > 22'sd524287) begin
         q_clip = 1'b1;
         q_sat = prod_ff[40] ? -20'sd524288 : 20'sd524287;
         if (prod_ff[40] && q == 22'sd524288) begin
            q_clip = 1'b0;
         end
      end else begin
         q_sat = prod_ff[40] ? -20'(q) : 20'(q);
      end
   end

   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      acc_in = acc_ff;
      clip_in = clip_ff;
      if (ctl.start) begin
         step_in = 4'd0;
         busy_in = 1'b1;
         clip_in = 1'b0;
      end else if (busy_ff && step_ff < 4'd12) begin
         step_in = step_ff + 4'd1;
      end
      if (prod_vld_ff && prod_step_ff < 4'd9) begin
         acc_in = (col_of(prod_step_ff) == 2'd0 ? 42'sd0 : acc_ff) + 42'(prod_ff);
      end
      if (prod_vld_ff && prod_step_ff < 4'd9 && col_of(prod_step_ff) == 2'd2) begin
         if (sum_t > 43'sd8388607 || sum_t < -43'sd8388608) begin
            clip_in = 1'b1;
         end
      end
      if (prod_vld_ff && prod_step_ff >= 4'd9 && q_clip) begin
         clip_in = 1'b1;
      end
      if (prod_vld_ff && prod_step_ff == 4'd11) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 4'd0;
         busy_ff <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         prod_vld_ff <= busy_ff && step_ff < 4'd12 && !ctl.start;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= 41'(mul_a * mul_b);
      prod_step_ff <= step_ff;
      acc_ff <= acc_in;
      clip_ff <= clip_in;
      if (prod_vld_ff && prod_step_ff < 4'd9 && col_of(prod_step_ff) == 2'd2) begin
         if (sum_t > 43'sd8388607) begin
            pt_ff[row_of(prod_step_ff)] <= 24'sd8388607;
         end else if (sum_t < -43'sd8388608) begin
            pt_ff[row_of(prod_step_ff)] <= -24'sd8388608;
         end else begin
            pt_ff[row_of(prod_step_ff)] <= 24'(sum_t);
         end
      end
      if (prod_vld_ff && prod_step_ff >= 4'd9) begin
         cl_ff[2'(prod_step_ff - 4'd9)] <= q_sat;
      end
   end

   assign sts.done = prod_vld_ff && prod_step_ff == 4'd11;
   assign pt_x = pt_ff[0];
   assign pt_y = pt_ff[1];
   assign pt_z = pt_ff[2];
   assign cl_x = cl_ff[0];
   assign cl_y = cl_ff[1];
   assign cl_z = cl_ff[2];
   assign clip = clip_ff;
   logic unused_crow;
   assign unused_crow = ^crow;
endmodule
`default_nettype wire

### src/vga_checker.sv
`default_nettype none
`include "assert_macros.svh"
module vga_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [2:0] rsp_status,
   input wire logic [10:0] rsp_count
);
   import vga_pkg::*;

   `ASSERT_IMPL(a_status_legal, clock, reset, rsp_valid, rsp_status <= ST_BAD_INDEX, "bad status")
   `ASSERT_IMPL(a_no_accept_busy, clock, reset, rsp_valid, !req_ready, "ready while rsp held")
   `ASSERT_NEXT(a_accept_drops_ready, clock, reset, req_valid && req_ready, !req_ready, "ready after accept")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_count), "rsp dropped")
   `ASSERT_IMPL(a_count_range, clock, reset, rsp_valid, rsp_count <= 11'(TableDepth), "count range")
endmodule

bind voxel_grid_point_accumulator_core vga_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.data.status),
   .rsp_count(rsp.data.entry_count)
);
`default_nettype wire

### tb/sv/tb_voxel_grid_point_accumulator_core.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_voxel_grid_point_accumulator_core;
   import vga_pkg::*;

   class voxel_store_board;
      logic [47:0] rot[3];
      logic signed [23:0] trans[3];
      logic [15:0] scale;
      logic [59:0] keys[TableDepth];
      logic signed [23:0] px[TableDepth];
      logic signed [23:0] py[TableDepth];
      logic signed [23:0] pz[TableDepth];
      int count;
      rsp_type pending[$];
      int errors;

      function new();
         rot[0] = 48'd16384;
         rot[1] = 48'd1073741824;
         rot[2] = 48'd70368744177664;
         foreach (trans[k]) trans[k] = '0;
         scale = 16'd5120;
         count = 0;
         errors = 0;
      endfunction

      function void set_reg(logic [CsrIdxW-1:0] idx, logic [CsrW-1:0] v);
         case (idx)
            CSR_ROT_X: rot[0] = v;
            CSR_ROT_Y: rot[1] = v;
            CSR_ROT_Z: rot[2] = v;
            CSR_TRANS_X: trans[0] = v[23:0];
            CSR_TRANS_Y: trans[1] = v[23:0];
            CSR_TRANS_Z: trans[2] = v[23:0];
            CSR_SCALE: scale = v[15:0];
            default: ;
         endcase
      endfunction

      function void note_request(req_type_type r);
         rsp_type e;
         longint p[3], acc, pt[3], prod, q;
         logic [59:0] key;
         bit clip, found;
         e = '0;
         clip = 0;
         if (r.req_type == 1'b0) begin
            p[0] = longint'(r.pos_x);
            p[1] = longint'(r.pos_y);
            p[2] = longint'(r.pos_z);
            for (int j = 0; j < 3; j++) begin
               acc = 0;
               for (int k = 0; k < 3; k++)
                  acc += longint'($signed(rot[j][16*k +: 16])) * p[k];
               acc = (acc >>> 14) + longint'(trans[j]);
               if (acc > 8388607) begin acc = 8388607; clip = 1; end
               if (acc < -8388608) begin acc = -8388608; clip = 1; end
               pt[j] = acc;
            end
            e.out_x = 24'(pt[0]);
            e.out_y = 24'(pt[1]);
            e.out_z = 24'(pt[2]);
            for (int j = 0; j < 3; j++) begin
               prod = pt[j] * longint'({1'b0, scale});
               q = (prod < 0) ? -((-prod) >> 20) : (prod >> 20);
               if (q > 524287) begin q = 524287; clip = 1; end
               if (q < -524288) begin q = -524288; clip = 1; end
               key[20*j +: 20] = 20'(q);
            end
            e.cell_x = key[19:0];
            e.cell_y = key[39:20];
            e.cell_z = key[59:40];
            found = 0;
            for (int i = 0; i < count; i++)
               if (keys[i] == key) begin found = 1; break; end
            if (found) e.status = ST_OCCUPIED;
            else if (count >= TableDepth) e.status = ST_FULL;
            else begin
               keys[count] = key;
               px[count] = 24'(pt[0]);
               py[count] = 24'(pt[1]);
               pz[count] = 24'(pt[2]);
               count++;
               e.status = ST_INSERTED;
            end
            e.clipped = clip;
         end else if (r.read_index < count) begin
            e.status = ST_READ_OK;
            e.out_x = px[r.read_index];
            e.out_y = py[r.read_index];
            e.out_z = pz[r.read_index];
            e.cell_x = keys[r.read_index][19:0];
            e.cell_y = keys[r.read_index][39:20];
            e.cell_z = keys[r.read_index][59:40];
         end else begin
            e.status = ST_BAD_INDEX;
         end
         e.entry_count = 11'(count);
         pending = {pending, e};
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t unexpected beat got %p", $time, a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a !== e) begin
            $display("%0t mismatch expected %p actual %p", $time, e, a);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [CsrIdxW-1:0] csr_index;
   logic [CsrW-1:0] csr_data;
   vga_req_if req_ch();
   vga_rsp_if rsp_ch();
   voxel_store_board board;
   longint cycles;
   bit stall_on;

   voxel_grid_point_accumulator_core i_dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      board = new();
      reset = 1;
      csr_we = 0;
      csr_index = '0;
      csr_data = '0;
      req_ch.valid = 0;
      req_ch.data = '0;
      rsp_ch.ready = 0;
      stall_on = 0;
      cycles = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 64'd6000000) begin
         $display("tb_voxel_grid_point_accumulator_core NOT OK");
         $finish;
      end
   end

   // receiver: alternating stall and flow stretches
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) board.check_response(rsp_ch.data);
         if ($urandom_range(0, 15) == 0) stall_on <= ~stall_on;
         rsp_ch.ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
      end
   end

   task automatic write_reg(logic [CsrIdxW-1:0] idx, logic [CsrW-1:0] v);
      csr_we <= 1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      csr_we <= 0;
      board.set_reg(idx, v);
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic send_beat(req_type_type r);
      req_ch.valid <= 1;
      req_ch.data <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic idle_gap();
      req_ch.valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   function automatic req_type_type add_point(int x, int y, int z);
      req_type_type r;
      r = '0;
      r.pos_x = 24'(x);
      r.pos_y = 24'(y);
      r.pos_z = 24'(z);
      return r;
   endfunction

   function automatic req_type_type read_at(int idx);
      req_type_type r;
      r = 83'({$urandom, $urandom, $urandom});
      r.req_type = 1'b1;
      r.read_index = 10'(idx);
      return r;
   endfunction

   function automatic req_type_type random_beat(int span, int count);
      req_type_type r;
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
         r = add_point($urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
            $urandom_range(0, 2 * span) - span);
         r.read_index = 10'($urandom);
      end else if (sel < 7) begin
         r = 83'({$urandom, $urandom, $urandom});
         r.pos_x = 24'($urandom);
         r.req_type = 1'b0;
      end else begin
         r = read_at((sel == 9) ? $urandom_range(0, 1023) : $urandom_range(0, count));
      end
      return r;
   endfunction

   task automatic random_phase(int n, int span);
      int left;
      int burst;
      left = n;
      while (left > 0) begin
         burst = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 12);
         for (int i = 0; i < burst && left > 0; i++, left--)
            send_beat(random_beat(span, board.count));
         if ($urandom_range(0, 2) != 0) idle_gap();
      end
      req_ch.valid <= 0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed
      send_beat(read_at(0));
      send_beat(add_point(0, 0, 0));
      send_beat(add_point(100, 100, 100));
      send_beat(add_point(8388607, -8388608, 8388607));
      send_beat(add_point(-8388608, 8388607, -8388608));
      send_beat(add_point(-1, -1, -1));
      send_beat(add_point(204800, -204800, 1));
      send_beat(read_at(0));
      send_beat(read_at(3));
      send_beat(read_at(5));
      send_beat(read_at(1023));
      idle_gap();
      drain();
      write_reg(CSR_ROT_X, 48'h8000_7FFF_8000);
      write_reg(CSR_ROT_Y, 48'h7FFF_7FFF_7FFF);
      write_reg(CSR_ROT_Z, 48'hC000_4000_FFFF);
      write_reg(CSR_TRANS_X, 48'h7FFFFF);
      write_reg(CSR_TRANS_Y, 48'h800000);
      write_reg(CSR_TRANS_Z, 48'h001000);
      write_reg(CSR_SCALE, 48'hFFFF);
      send_beat(add_point(8388607, 8388607, 8388607));
      send_beat(add_point(-8388608, -8388608, -8388608));
      send_beat(add_point(12345, -777, 4096));
      req_ch.valid <= 0;
      drain();
      write_reg(CSR_SCALE, 48'h0);
      send_beat(add_point(1000, 2000, 3000));
      send_beat(add_point(-5000, 9, 77));
      send_beat(read_at(board.count - 1));
      req_ch.valid <= 0;
      drain();
      // random phases over several settings
      write_reg(CSR_ROT_X, 48'd16384);
      write_reg(CSR_ROT_Y, 48'd1073741824);
      write_reg(CSR_ROT_Z, 48'd70368744177664);
      write_reg(CSR_TRANS_X, 48'h0);
      write_reg(CSR_TRANS_Y, 48'h0);
      write_reg(CSR_TRANS_Z, 48'h0);
      write_reg(CSR_SCALE, 48'd5120);
      random_phase(200, 20000);
      drain();
      write_reg(CSR_SCALE, 48'd1);
      write_reg(CSR_TRANS_X, {24'h0, 24'($urandom)});
      write_reg(CSR_ROT_Y, 48'({$urandom, $urandom}));
      random_phase(150, 8388607);
      drain();
      write_reg(CSR_SCALE, 48'hFFFF);
      write_reg(CSR_ROT_X, 48'({$urandom, $urandom}));
      write_reg(CSR_TRANS_Z, {24'h0, 24'($urandom)});
      random_phase(200, 400000);
      drain();
      if (board.errors == 0 && board.pending.size() == 0)
         $display("tb_voxel_grid_point_accumulator_core OK");
      else
         $display("tb_voxel_grid_point_accumulator_core NOT OK");
      $finish;
   end
endmodule
`default_nettype wire

### tb/sv/tb_voxel_grid_point_accumulator_core_if_note.sv
`timescale 1ns / 100ps
